// ===== rtl/dcma_pkg.sv =====
// Package for the dual channel moving average core.
// Holds the shared widths, register codes, reset values, FSM states and status structs.
// Depends on nothing.
`timescale 1ns / 1ps

package dcma_pkg;

  // Default build parameters.
  localparam int unsigned DEF_WINDOW_DEPTH = 64;
  localparam int unsigned DEF_SAMPLE_BITS  = 12;

  // Threshold registers and the reported averages are 12 bits wide.
  localparam int unsigned REG_W = 12;
  localparam int unsigned AVG_W = 12;

  localparam logic [REG_W-1:0] MIN_VALID_RESET = 12'd600;
  localparam logic [REG_W-1:0] MAX_VALID_RESET = 12'd4095;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_VALID = 1'b0;
  localparam logic REG_MAX_VALID = 1'b1;

  // Input function codes.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic busy;   // ring update in flight
    logic empty;  // no sample pair buffered yet
  } ring_status_t;

  typedef struct packed {
    logic busy;   // division steps still running
    logic done;   // quotients valid and held
  } div_status_t;

endpackage

// ===== rtl/dcma_ring.sv =====
// Sample ring memory with running sums, write index and fill count for both channels.
// Depends on dcma_pkg.
`timescale 1ns / 1ps

module dcma_ring
  import dcma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH),
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sin_i,
  input  logic [SAMPLE_BITS-1:0] cos_i,
  output logic [SUM_W-1:0]       sin_sum_o,
  output logic [SUM_W-1:0]       cos_sum_o,
  output logic [CNT_W-1:0]       fill_o,
  output ring_status_t           status_o
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW_DEPTH - 1);

  // Both channels share one entry: cosine in the upper half, sine in the lower.
  logic [2*SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rdata_q;

  logic                   pending_q;
  logic [SAMPLE_BITS-1:0] new_sin_q, new_cos_q;
  logic [IDX_W-1:0]       widx_q, widx_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sin_sum_q, sin_sum_d, cos_sum_q, cos_sum_d;
  logic [SAMPLE_BITS-1:0] old_sin, old_cos;
  logic                   full;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rdata_q <= mem[widx_q];
    end
    if (pending_q) begin
      mem[widx_q] <= {new_cos_q, new_sin_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      new_sin_q <= sin_i;
      new_cos_q <= cos_i;
    end
  end

  // Until the ring is full, the slot being overwritten was never written and is read as zero.
  assign full    = (fill_q == FULL_COUNT);
  assign old_sin = full ? rdata_q[SAMPLE_BITS-1:0] : '0;
  assign old_cos = full ? rdata_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;

  always_comb begin
    sin_sum_d = sin_sum_q;
    cos_sum_d = cos_sum_q;
    widx_d    = widx_q;
    fill_d    = fill_q;
    if (pending_q) begin
      sin_sum_d = sin_sum_q - SUM_W'(old_sin) + SUM_W'(new_sin_q);
      cos_sum_d = cos_sum_q - SUM_W'(old_cos) + SUM_W'(new_cos_q);
      widx_d    = (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
      if (!full) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      widx_q    <= '0;
      fill_q    <= '0;
      sin_sum_q <= '0;
      cos_sum_q <= '0;
    end else begin
      pending_q <= push_i;
      widx_q    <= widx_d;
      fill_q    <= fill_d;
      sin_sum_q <= sin_sum_d;
      cos_sum_q <= cos_sum_d;
    end
  end

  assign sin_sum_o      = sin_sum_q;
  assign cos_sum_o      = cos_sum_q;
  assign fill_o         = fill_q;
  assign status_o.busy  = pending_q;
  assign status_o.empty = (fill_q == '0);

endmodule

// ===== rtl/dcma_div.sv =====
// Two-lane restoring divider that forms the rounded means floor((2*sum + n) / (2*n)).
// One quotient bit per lane per cycle. Depends on dcma_pkg.
`timescale 1ns / 1ps

module dcma_div
  import dcma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SUM_W-1:0]       sin_sum_i,
  input  logic [SUM_W-1:0]       cos_sum_i,
  input  logic [CNT_W-1:0]       count_i,
  output logic [SAMPLE_BITS-1:0] q_sin_o,
  output logic [SAMPLE_BITS-1:0] q_cos_o,
  output div_status_t            status_o
);

  localparam int unsigned NUM_W  = SUM_W + 2;
  localparam int unsigned DEN_W  = CNT_W + 1;
  localparam int unsigned STEP_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [STEP_W-1:0] STEPS = STEP_W'(SAMPLE_BITS);

  // The mean never exceeds the largest sample, so SAMPLE_BITS quotient bits suffice and
  // the numerator bits above them start out as a partial remainder below the divisor.
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W-1:0]       rem_q [2];
  logic [DEN_W-1:0]       rem_d [2];
  logic [SAMPLE_BITS-1:0] lo_q  [2];
  logic [SAMPLE_BITS-1:0] lo_d  [2];
  logic [SAMPLE_BITS-1:0] quo_q [2];
  logic [SAMPLE_BITS-1:0] quo_d [2];
  logic [NUM_W-1:0]       num   [2];
  logic [SUM_W-1:0]       sums  [2];
  logic [STEP_W-1:0]      step_q;
  logic                   busy_q, done_q;

  assign sums[0] = sin_sum_i;
  assign sums[1] = cos_sum_i;

  always_comb begin
    logic [DEN_W:0] trial;
    logic           ge;
    for (int l = 0; l < 2; l++) begin
      num[l]   = {1'b0, sums[l], 1'b0} + NUM_W'(count_i);
      trial    = {rem_q[l], lo_q[l][SAMPLE_BITS-1]};
      ge       = (trial >= {1'b0, den_q});
      rem_d[l] = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      lo_d[l]  = lo_q[l] << 1;
      quo_d[l] = {quo_q[l][SAMPLE_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= {count_i, 1'b0};
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= DEN_W'(num[l][NUM_W-1:SAMPLE_BITS]);
        lo_q[l]  <= num[l][SAMPLE_BITS-1:0];
        quo_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_d[l];
        lo_q[l]  <= lo_d[l];
        quo_q[l] <= quo_d[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= STEPS;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign q_sin_o       = quo_q[0];
  assign q_cos_o       = quo_q[1];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== rtl/dual_channel_moving_average_core.sv =====
// Dual channel moving average core: a push transaction reads the ring, then updates the sums
// and writes back; a read transaction runs the one-bit-per-cycle divider and registers its
// result, and the next transaction is taken only once that result is loaded into the output
// register. Reset is asynchronous, active low; it empties the ring by clearing the fill count,
// so the sample memory itself needs no clearing pass.
`timescale 1ns / 1ps

module dual_channel_moving_average_core
  import dcma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int unsigned IN_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,  // sin_sample, cos_sample, zero padding
  input  logic [0:0]           s_axis_tuser_i,  // func
  // Result stream.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [23:0]          m_axis_tdata_o,  // avg_sin, avg_cos
  output logic [1:0]           m_axis_tuser_o,  // no_data, no_signal
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned CMP_W = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase; pready is tied
  // high, so there are never wait states. Register index is address bit 2.
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] min_valid_q, max_valid_q;
  logic             cfg_write;
  logic             reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q <= MIN_VALID_RESET;
      max_valid_q <= MAX_VALID_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MIN_VALID: min_valid_q <= pwdata[REG_W-1:0];
        REG_MAX_VALID: max_valid_q <= pwdata[REG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_VALID: prdata = 32'(min_valid_q);
      REG_MAX_VALID: prdata = 32'(max_valid_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Transaction decode. One transaction is worked on at a time; the controller
  // only accepts in the idle state.
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_accept, push_accept, read_accept;
  logic [SAMPLE_BITS-1:0] sin_in, cos_in;

  assign sin_in      = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign cos_in      = s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign push_accept = in_accept && (s_axis_tuser_i[0] == FUNC_PUSH);
  assign read_accept = in_accept && (s_axis_tuser_i[0] == FUNC_READ);

  // ---------------------------------------------------------------------------
  // Ring memory and running sums.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sin_sum, cos_sum;
  logic [CNT_W-1:0] fill;
  ring_status_t     ring_status;

  dcma_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_accept),
    .sin_i     (sin_in),
    .cos_i     (cos_in),
    .sin_sum_o (sin_sum),
    .cos_sum_o (cos_sum),
    .fill_o    (fill),
    .status_o  (ring_status)
  );

  // ---------------------------------------------------------------------------
  // Rounded mean divider. The sums and fill count hold still during a read.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] q_sin, q_cos;
  div_status_t            div_status;

  dcma_div #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (read_accept),
    .sin_sum_i (sin_sum),
    .cos_sum_i (cos_sum),
    .count_i   (fill),
    .q_sin_o   (q_sin),
    .q_cos_o   (q_cos),
    .status_o  (div_status)
  );

  // ---------------------------------------------------------------------------
  // Controller. A finished read waits in ST_DIV only while the output register
  // still holds an untaken result.
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (push_accept) begin
          state_d = ST_PUSH;
        end else if (read_accept) begin
          state_d = ST_DIV;
        end
      end
      ST_PUSH: begin
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_status.done && (!out_valid_q || m_axis_tready_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register. An empty ring reports zero averages with only no_data set;
  // otherwise no_signal flags an average outside [min_valid, max_valid].
  // ---------------------------------------------------------------------------
  logic [AVG_W-1:0] avg_sin_q, avg_cos_q;
  logic             no_data_q, no_signal_q;
  logic             sin_ok, cos_ok;

  assign sin_ok = (CMP_W'(q_sin) >= CMP_W'(min_valid_q)) &&
                  (CMP_W'(q_sin) <= CMP_W'(max_valid_q));
  assign cos_ok = (CMP_W'(q_cos) >= CMP_W'(min_valid_q)) &&
                  (CMP_W'(q_cos) <= CMP_W'(max_valid_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (ring_status.empty) begin
        avg_sin_q   <= '0;
        avg_cos_q   <= '0;
        no_data_q   <= 1'b1;
        no_signal_q <= 1'b0;
      end else begin
        avg_sin_q   <= AVG_W'(q_sin);
        avg_cos_q   <= AVG_W'(q_cos);
        no_data_q   <= 1'b0;
        no_signal_q <= !(sin_ok && cos_ok);
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {avg_cos_q, avg_sin_q};
  assign m_axis_tuser_o  = {no_signal_q, no_data_q};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_push_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_accept |=> ring_status.busy)
    else $error("push transaction did not start a ring update");

  a_no_accept_during_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_status.busy || div_status.busy) |-> !s_axis_tready_o)
    else $error("input accepted while a ring update or division is in flight");

  a_load_after_division: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (div_status.done && !div_status.busy))
    else $error("result loaded before the division finished");

  a_hold_untaken_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(m_axis_tdata_o)))
    else $error("untaken result was changed or dropped");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the dual channel moving average core.
// Depends on dcma_pkg, dual_channel_moving_average_core, dcma_ring and dcma_div.
`timescale 1ns / 1ps

module testbench;
  import dcma_pkg::*;

  localparam int unsigned DEPTH = DEF_WINDOW_DEPTH;
  localparam int unsigned SBITS = DEF_SAMPLE_BITS;
  localparam int unsigned IN_W  = ((2 * SBITS + 7) / 8) * 8;
  // After the last result has come back, this many quiet cycles are enough
  // for any transaction still in flight to finish.
  localparam int unsigned DRAIN_CYCLES = SBITS + 10;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASES       = 6;

  typedef struct packed {
    logic [AVG_W-1:0] avg_sin;
    logic [AVG_W-1:0] avg_cos;
    logic             no_data;
    logic             no_signal;
  } avg_result_t;

  // Scoreboard: tracks the ring contents and running sums on its own, and
  // holds the averages that pending read transactions must return.
  class avg_scoreboard;
    logic [SBITS-1:0] sin_hist [DEPTH];
    logic [SBITS-1:0] cos_hist [DEPTH];
    int unsigned      slot;
    int unsigned      fill;
    int unsigned      sin_total;
    int unsigned      cos_total;
    logic [REG_W-1:0] lo_limit;
    logic [REG_W-1:0] hi_limit;
    avg_result_t      expected_avgs [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        sin_hist[i] = '0;
        cos_hist[i] = '0;
      end
      slot      = 0;
      fill      = 0;
      sin_total = 0;
      cos_total = 0;
      lo_limit  = MIN_VALID_RESET;
      hi_limit  = MAX_VALID_RESET;
      errors    = 0;
    endfunction

    function void set_threshold(logic idx, logic [31:0] value);
      if (idx == REG_MIN_VALID) begin
        lo_limit = value[REG_W-1:0];
      end else begin
        hi_limit = value[REG_W-1:0];
      end
    endfunction

    // Average rounded half up: floor((2*sum + n) / (2*n)).
    function logic [AVG_W-1:0] rounded_avg(int unsigned total, int unsigned n);
      int unsigned q;
      q = (2 * total + n) / (2 * n);
      return q[AVG_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_avgs.size();
    endfunction

    function void note_transaction(logic func, logic [SBITS-1:0] s, logic [SBITS-1:0] c);
      avg_result_t r;
      if (func == FUNC_PUSH) begin
        sin_total = sin_total - sin_hist[slot] + s;
        cos_total = cos_total - cos_hist[slot] + c;
        sin_hist[slot] = s;
        cos_hist[slot] = c;
        slot = (slot + 1) % DEPTH;
        if (fill < DEPTH) fill++;
      end else if (fill == 0) begin
        r = '{avg_sin: '0, avg_cos: '0, no_data: 1'b1, no_signal: 1'b0};
        expected_avgs.push_back(r);
      end else begin
        r.avg_sin   = rounded_avg(sin_total, fill);
        r.avg_cos   = rounded_avg(cos_total, fill);
        r.no_data   = 1'b0;
        r.no_signal = !(r.avg_sin >= lo_limit && r.avg_sin <= hi_limit &&
                        r.avg_cos >= lo_limit && r.avg_cos <= hi_limit);
        expected_avgs.push_back(r);
      end
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [23:0] data, logic [1:0] flags);
      avg_result_t e;
      if (expected_avgs.size() == 0) begin
        report("unexpected result transaction, avg_sin", int'(data[11:0]), -1);
      end else begin
        e = expected_avgs.pop_front();
        if (data[11:0] !== e.avg_sin) begin
          report("avg_sin", int'(data[11:0]), int'(e.avg_sin));
        end
        if (data[23:12] !== e.avg_cos) begin
          report("avg_cos", int'(data[23:12]), int'(e.avg_cos));
        end
        if (flags[0] !== e.no_data) begin
          report("no_data", int'(flags[0]), int'(e.no_data));
        end
        if (flags[1] !== e.no_signal) begin
          report("no_signal", int'(flags[1]), int'(e.no_signal));
        end
      end
    endtask
  endclass

  // Clock, reset and every block input start at a known value.
  logic            clk_i     = 1'b0;
  logic            rst_n     = 1'b0;
  logic            s_valid   = 1'b0;
  logic [IN_W-1:0] s_data    = '0;
  logic [0:0]      s_func    = FUNC_PUSH;
  logic            m_ready   = 1'b0;
  logic            psel      = 1'b0;
  logic            penable   = 1'b0;
  logic            pwrite    = 1'b0;
  logic [2:0]      paddr     = '0;
  logic [31:0]     pwdata    = '0;

  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [23:0]     m_axis_tdata_o;
  logic [1:0]      m_axis_tuser_o;
  logic [31:0]     prdata;
  logic            pready;

  // Idling controls, set per phase by the stimulus thread.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Each increment of hold_req asks the receiver for one long hold-off.
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  avg_scoreboard sb;

  always #10 clk_i = ~clk_i;

  dual_channel_moving_average_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),   // sin_sample, cos_sample
    .s_axis_tuser_i  (s_func),   // func
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // avg_sin, avg_cos
    .m_axis_tuser_o  (m_axis_tuser_o),  // no_data, no_signal
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Receiver: random back-pressure, plus a long hold-off whenever one is
  // requested. The hold-off is counted here so the sender keeps offering
  // transactions while the output is blocked and the core has to stall.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitors sample at the rising edge, so they see the values that were
  // present at the edge and never the ones being driven for the next cycle.
  always @(posedge clk_i) begin
    if (rst_n && s_valid && s_axis_tready_o) begin
      sb.note_transaction(s_func[0], s_data[SBITS-1:0], s_data[2*SBITS-1:SBITS]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Offers one transaction and returns at the edge where it is accepted.
  // Valid is left high so back-to-back transactions need no second
  // assignment in the same time step.
  task automatic send_item(logic func, logic [SBITS-1:0] s, logic [SBITS-1:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_valid <= 1'b1;
    s_func  <= func;
    s_data  <= {c, s};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stops offering and waits until every pending average has come back,
  // then lets any push still in flight finish.
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write with a setup phase and an access phase; psel is dropped
  // before the task returns, so a second write can start right away; the
  // upper data bits are random since the core must ignore them.
  task automatic apb_write(logic idx, int unsigned value);
    logic [31:0] wdata;
    wdata        = $urandom;
    wdata[11:0]  = value[11:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_threshold(idx, wdata);
    @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  function automatic logic [SBITS-1:0] pick_sample(int base, int spread);
    int v;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    if (roll < 20) return SBITS'($urandom);
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SBITS-1:0];
  endfunction

  // Random traffic: mostly pushes, with reads often enough to watch the
  // window fill, saturate and wrap. Reads carry random sample bits too.
  task automatic random_item(int base, int spread);
    logic func;
    func = ($urandom_range(99) < 30) ? FUNC_READ : FUNC_PUSH;
    send_item(func, pick_sample(base, spread), pick_sample(base, spread));
  endtask

  initial begin
    int base;
    int spread;
    int lo;
    int hi;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset thresholds. A read before any push must
    // flag missing data; mixing the extremes gives an exact half, which
    // has to round up; the low samples fall below the valid window.
    set_idling(0);
    send_item(FUNC_READ, '1, '1);
    send_item(FUNC_PUSH, '0, '0);
    send_item(FUNC_READ, '0, '0);
    send_item(FUNC_PUSH, '1, '1);
    send_item(FUNC_READ, '0, '1);
    send_item(FUNC_PUSH, 12'd1, 12'd2);
    send_item(FUNC_READ, '1, '0);
    send_item(FUNC_PUSH, 12'd600, 12'd599);
    send_item(FUNC_READ, '0, '0);
    send_item(FUNC_PUSH, 12'hAAA, 12'h555);
    send_item(FUNC_PUSH, 12'h555, 12'hAAA);
    send_item(FUNC_READ, 12'h555, 12'hAAA);
    send_item(FUNC_PUSH, '1, '0);
    send_item(FUNC_READ, '1, '1);

    for (int p = 0; p < PHASES; p++) begin
      base   = $urandom_range(4095);
      spread = ($urandom_range(1)) ? 40 : 1500;
      if (p > 0) begin
        settle();
        case (p)
          1: begin lo = 0;    hi = 4095; end
          // Inverted window: every read with data must flag no signal.
          2: begin lo = 4095; hi = 0;    end
          // Single-value window right at mid scale.
          3: begin lo = 2048; hi = 2048; base = 2048; spread = 1; end
          4: begin
            lo = base - int'($urandom_range(200));
            hi = base + int'($urandom_range(200));
            if (lo < 0) lo = 0;
            if (hi > 4095) hi = 4095;
          end
          default: begin lo = $urandom_range(4095); hi = $urandom_range(4095); end
        endcase
        apb_write(REG_MIN_VALID, lo);
        apb_write(REG_MAX_VALID, hi);
      end
      set_idling(p % 4);
      // With the sender at full speed, block the output for a long stretch.
      if (p == 0 || p == 4) hold_req++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Halfway through one phase the sender waits for all results.
        if (p == 4 && i == PHASE_ITEMS / 2) settle();
        random_item(base, spread);
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dcma_pkg.sv
rtl/dcma_ring.sv
rtl/dcma_div.sv
rtl/dual_channel_moving_average_core.sv
tb/sv/testbench.sv
